// File: hw/rtl/rbsi_pkg.sv
// shared constants and types for the ray box slab intersection unit
package rbsi_pkg;

  localparam int FracBits = 16;
  localparam int CoordW   = 32;
  localparam int NumAxes  = 3;
  localparam int NumLanes = 2 * NumAxes;
  // numerator magnitude of one slab time, also the quotient width
  localparam int NumW     = CoordW + FracBits;
  // signed slab time width
  localparam int TimeW    = NumW + 1;
  localparam int CfgIdxW  = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBoxMinX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBoxMinY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBoxMinZ = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBoxMaxX = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBoxMaxY = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgBoxMaxZ = 3'd5;

  // flags that travel alongside the divider lanes
  typedef struct packed {
    logic                limit;
    logic                in_box;
    logic                vfail;
    logic [NumAxes-1:0]  vzero;
    logic [NumLanes-1:0] neg;
  } side_t;

endpackage

// File: hw/rtl/rbsi_if.sv
// request and result channel interfaces
interface rbsi_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbsi_pkg::CoordW-1:0]  origin_x;
  logic signed [rbsi_pkg::CoordW-1:0]  origin_y;
  logic signed [rbsi_pkg::CoordW-1:0]  origin_z;
  logic signed [rbsi_pkg::CoordW-1:0]  velocity_x;
  logic signed [rbsi_pkg::CoordW-1:0]  velocity_y;
  logic signed [rbsi_pkg::CoordW-1:0]  velocity_z;
  logic                                limit_to_segment;

  modport source (output valid, origin_x, origin_y, origin_z, velocity_x, velocity_y,
                  velocity_z, limit_to_segment, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, velocity_x, velocity_y,
                velocity_z, limit_to_segment, output ready);
endinterface

interface rbsi_res_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [rbsi_pkg::CoordW-1:0]  hit_time;

  modport source (output valid, hit, hit_time, input ready);
  modport sink (input valid, hit, hit_time, output ready);
endinterface

// File: hw/rtl/ray_box_slab_intersect_unit.sv
// ray versus box slab test, fully pipelined with one divider stage per quotient bit
// throughput: one request per cycle; a stalled result freezes the whole pipeline
// the depth is set by the restoring dividers, six lanes each retiring one quotient bit a stage
// reset: asynchronous active low, clears box registers to zero and empties the pipeline
module ray_box_slab_intersect_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbsi_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rbsi_pkg::CoordW-1:0]     cfg_data_i,
  rbsi_req_if.sink                        in_i,
  rbsi_res_if.source                      out_o
);

  localparam int W   = rbsi_pkg::CoordW;
  localparam int F   = rbsi_pkg::FracBits;
  localparam int NW  = rbsi_pkg::NumW;
  localparam int TW  = rbsi_pkg::TimeW;
  localparam int NA  = rbsi_pkg::NumAxes;
  localparam int NL  = rbsi_pkg::NumLanes;

  localparam logic signed [TW-1:0] TimeInf = {1'b0, {NW{1'b1}}};
  localparam logic signed [TW-1:0] TimeOne = TW'(1) << F;
  localparam logic signed [TW-1:0] TimeSat = TW'({1'b0, {(W-1){1'b1}}});

  // box registers
  logic signed [W-1:0] box_lo_q [NA];
  logic signed [W-1:0] box_hi_q [NA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NA; a++) begin
        box_lo_q[a] <= '0;
        box_hi_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbsi_pkg::CfgBoxMinX: box_lo_q[0] <= cfg_data_i;
        rbsi_pkg::CfgBoxMinY: box_lo_q[1] <= cfg_data_i;
        rbsi_pkg::CfgBoxMinZ: box_lo_q[2] <= cfg_data_i;
        rbsi_pkg::CfgBoxMaxX: box_hi_q[0] <= cfg_data_i;
        rbsi_pkg::CfgBoxMaxY: box_hi_q[1] <= cfg_data_i;
        rbsi_pkg::CfgBoxMaxZ: box_hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the result register is held
  logic en;
  logic out_valid_q;
  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // front stage: differences, magnitudes and signs
  logic signed [W-1:0] org [NA];
  logic signed [W-1:0] vel [NA];
  assign org[0] = in_i.origin_x;
  assign org[1] = in_i.origin_y;
  assign org[2] = in_i.origin_z;
  assign vel[0] = in_i.velocity_x;
  assign vel[1] = in_i.velocity_y;
  assign vel[2] = in_i.velocity_z;

  logic [NW-1:0]        num_d  [NL];
  logic [W-1:0]         dv_d   [NA];
  rbsi_pkg::side_t      side_d;

  always_comb begin
    logic signed [W:0] dhi;
    logic signed [W:0] dlo;
    logic [W:0]        mhi;
    logic [W:0]        mlo;
    logic              in_slab;
    side_d        = '0;
    side_d.limit  = in_i.limit_to_segment;
    side_d.in_box = 1'b1;
    for (int a = 0; a < NA; a++) begin
      dhi = {box_hi_q[a][W-1], box_hi_q[a]} - {org[a][W-1], org[a]};
      dlo = {box_lo_q[a][W-1], box_lo_q[a]} - {org[a][W-1], org[a]};
      mhi = dhi[W] ? (W+1)'(-dhi) : (W+1)'(dhi);
      mlo = dlo[W] ? (W+1)'(-dlo) : (W+1)'(dlo);
      num_d[2*a]   = {mhi[W-1:0], {F{1'b0}}};
      num_d[2*a+1] = {mlo[W-1:0], {F{1'b0}}};
      dv_d[a]      = vel[a][W-1] ? W'(-vel[a]) : W'(vel[a]);
      side_d.neg[2*a]   = dhi[W] ^ vel[a][W-1];
      side_d.neg[2*a+1] = dlo[W] ^ vel[a][W-1];
      in_slab = (org[a] >= box_lo_q[a]) && (org[a] <= box_hi_q[a]);
      side_d.vzero[a] = (vel[a] == '0);
      if (!in_slab) begin
        side_d.in_box = 1'b0;
      end
      if (side_d.vzero[a] && !in_slab) begin
        side_d.vfail = 1'b1;
      end
    end
  end

  // divider pipeline storage, index k holds the state entering divider step k
  logic [NW:0]          vld_q;
  logic [W-1:0]         rem_q  [NW+1][NL];
  logic [NW-1:0]        num_q  [NW+1][NL];
  logic [W-1:0]         dv_q   [NW+1][NA];
  rbsi_pkg::side_t      side_q [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        rem_q[0][l] <= '0;
        num_q[0][l] <= num_d[l];
      end
      for (int a = 0; a < NA; a++) begin
        dv_q[0][a] <= dv_d[a];
      end
      side_q[0] <= side_d;
    end
  end

  // restoring divider steps, one quotient bit per lane per stage
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [W-1:0]  rem_d [NL];
    logic [NW-1:0] nq_d  [NL];

    always_comb begin
      logic [W:0] trial;
      logic [W:0] dvx;
      logic       ge;
      for (int l = 0; l < NL; l++) begin
        trial    = {rem_q[k][l], num_q[k][l][NW-1]};
        dvx      = {1'b0, dv_q[k][l/2]};
        ge       = (trial >= dvx);
        rem_d[l] = ge ? W'(trial - dvx) : W'(trial);
        nq_d[l]  = {num_q[k][l][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < NL; l++) begin
          rem_q[k+1][l] <= rem_d[l];
          num_q[k+1][l] <= nq_d[l];
        end
        for (int a = 0; a < NA; a++) begin
          dv_q[k+1][a] <= dv_q[k][a];
        end
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // sort stage: signed slab times, ordered per axis
  logic signed [TW-1:0] t1_d [NA];
  logic signed [TW-1:0] t2_d [NA];

  always_comb begin
    logic signed [TW-1:0] ta;
    logic signed [TW-1:0] tb;
    for (int a = 0; a < NA; a++) begin
      ta = side_q[NW].neg[2*a]   ? -$signed({1'b0, num_q[NW][2*a]})
                                 :  $signed({1'b0, num_q[NW][2*a]});
      tb = side_q[NW].neg[2*a+1] ? -$signed({1'b0, num_q[NW][2*a+1]})
                                 :  $signed({1'b0, num_q[NW][2*a+1]});
      t1_d[a] = (ta > tb) ? tb : ta;
      t2_d[a] = (ta > tb) ? ta : tb;
    end
  end

  logic                 srt_vld_q;
  logic signed [TW-1:0] t1_q [NA];
  logic signed [TW-1:0] t2_q [NA];
  rbsi_pkg::side_t      srt_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srt_vld_q <= 1'b0;
    end else if (en) begin
      srt_vld_q <= vld_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q       <= t1_d;
      t2_q       <= t2_d;
      srt_side_q <= side_q[NW];
    end
  end

  // fold stage over moving axes: entry is the latest start or zero, exit the earliest end
  logic signed [TW-1:0] enter_d;
  logic signed [TW-1:0] exit_d;

  always_comb begin
    enter_d = '0;
    exit_d  = TimeInf;
    for (int a = 0; a < NA; a++) begin
      if (!srt_side_q.vzero[a]) begin
        if (t1_q[a] > enter_d) begin
          enter_d = t1_q[a];
        end
        if (t2_q[a] < exit_d) begin
          exit_d = t2_q[a];
        end
      end
    end
  end

  logic                 fld_vld_q;
  logic signed [TW-1:0] enter_q;
  logic signed [TW-1:0] exit_q;
  rbsi_pkg::side_t      fld_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_vld_q <= 1'b0;
    end else if (en) begin
      fld_vld_q <= srt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      enter_q    <= enter_d;
      exit_q     <= exit_d;
      fld_side_q <= srt_side_q;
    end
  end

  // decision stage: pick time, apply segment limit and saturate
  logic                 hit_d;
  logic signed [W-1:0]  time_d;

  always_comb begin
    logic signed [TW-1:0] t;
    t      = (enter_q > 0) ? enter_q : exit_q;
    hit_d  = 1'b0;
    time_d = '0;
    if (fld_side_q.in_box) begin
      hit_d = 1'b1;
    end else if (!fld_side_q.vfail && !(enter_q > exit_q) && !(exit_q < 0) && !(t < 0)
                 && !(fld_side_q.limit && (t > TimeOne))) begin
      hit_d  = 1'b1;
      time_d = (t > TimeSat) ? TimeSat[W-1:0] : t[W-1:0];
    end
  end

  logic                hit_q;
  logic signed [W-1:0] time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fld_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      time_q <= time_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.hit      = hit_q;
  assign out_o.hit_time = time_q;

  // checks
  a_sort_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srt_vld_q |-> (t1_q[0] <= t2_q[0]) && (t1_q[1] <= t2_q[1]) && (t1_q[2] <= t2_q[2]))
    else $error("slab times out of order");

  a_enter_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_vld_q |-> (enter_q >= 0))
    else $error("entry time negative");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !hit_q) |-> (time_q == '0))
    else $error("miss carries a time");

  a_time_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !time_q[W-1])
    else $error("hit time negative");

endmodule
